// ----- sv/tcdtc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcdtc_pkg
// shared types, constants and round functions of the tweakable decrypt core
// ----------------------------------------------------------------------------
package tcdtc_pkg;

  localparam int NUM_ROUNDS = 7;
  localparam int TAG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int TB_W       = 5;
  localparam logic [TB_W-1:0] TAG_BITS_RESET = 5'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_TAG_BITS = 2'd2
  } cfg_reg_t;

  // linear layer constants: bit i = x[(A*i+B0)%n] ^ x[(A*i+B1)%n] ^ x[(A*i+B2)%n]
  localparam int LC1_A = 11, LC1_B0 = 5,  LC1_B1 = 9,  LC1_B2 = 12;
  localparam int LC2_A = 11, LC2_B0 = 1,  LC2_B1 = 26, LC2_B2 = 30;
  localparam int LT_A  = 3,  LT_B0  = 1,  LT_B1  = 26, LT_B2  = 50;
  localparam int LK_A  = 17, LK_B0  = 7,  LK_B1  = 11, LK_B2  = 14;

  typedef struct packed {
    logic [31:0]      c1;
    logic [31:0]      c2;
    logic [63:0]      t;
    logic [127:0]     k;
    logic [TAG_W-1:0] etag;
  } stage_t;

  function automatic logic [31:0] chichi32(input logic [31:0] x);
    localparam int N = 32;
    localparam int M = N / 2;
    logic [N-1:0] y;
    for (int i = 0; i < N; i++) begin
      if (i + 3 < M || (i > M && i + 2 < N))
        y[i] = x[i] ^ (~x[(i+1)%N] & x[(i+2)%N]);
      else if (i == M - 3) y[i] = x[M] ^ (~x[M-2] & x[0]);
      else if (i == M - 2) y[i] = x[M-1] ^ (~x[0] & x[1]);
      else if (i == M - 1) y[i] = ~x[M-3] ^ (~x[M] & ~x[M+1]);
      else if (i == M)     y[i] = x[M-2] ^ (~x[M+1] & x[M+2]);
      else if (i == N - 2) y[i] = x[N-2] ^ (~x[N-1] & x[M-1]);
      else                 y[i] = x[N-1] ^ (~x[M-1] & x[M]);
    end
    return y;
  endfunction

  function automatic logic [63:0] chichi64(input logic [63:0] x);
    localparam int N = 64;
    localparam int M = N / 2;
    logic [N-1:0] y;
    for (int i = 0; i < N; i++) begin
      if (i + 3 < M || (i > M && i + 2 < N))
        y[i] = x[i] ^ (~x[(i+1)%N] & x[(i+2)%N]);
      else if (i == M - 3) y[i] = x[M] ^ (~x[M-2] & x[0]);
      else if (i == M - 2) y[i] = x[M-1] ^ (~x[0] & x[1]);
      else if (i == M - 1) y[i] = ~x[M-3] ^ (~x[M] & ~x[M+1]);
      else if (i == M)     y[i] = x[M-2] ^ (~x[M+1] & x[M+2]);
      else if (i == N - 2) y[i] = x[N-2] ^ (~x[N-1] & x[M-1]);
      else                 y[i] = x[N-1] ^ (~x[M-1] & x[M]);
    end
    return y;
  endfunction

  function automatic logic [127:0] chichi128(input logic [127:0] x);
    localparam int N = 128;
    localparam int M = N / 2;
    logic [N-1:0] y;
    for (int i = 0; i < N; i++) begin
      if (i + 3 < M || (i > M && i + 2 < N))
        y[i] = x[i] ^ (~x[(i+1)%N] & x[(i+2)%N]);
      else if (i == M - 3) y[i] = x[M] ^ (~x[M-2] & x[0]);
      else if (i == M - 2) y[i] = x[M-1] ^ (~x[0] & x[1]);
      else if (i == M - 1) y[i] = ~x[M-3] ^ (~x[M] & ~x[M+1]);
      else if (i == M)     y[i] = x[M-2] ^ (~x[M+1] & x[M+2]);
      else if (i == N - 2) y[i] = x[N-2] ^ (~x[N-1] & x[M-1]);
      else                 y[i] = x[N-1] ^ (~x[M-1] & x[M]);
    end
    return y;
  endfunction

  function automatic logic [31:0] lin_c1(input logic [31:0] x);
    logic [31:0] y;
    for (int i = 0; i < 32; i++)
      y[i] = x[(LC1_A*i + LC1_B0) % 32] ^ x[(LC1_A*i + LC1_B1) % 32]
           ^ x[(LC1_A*i + LC1_B2) % 32];
    return y;
  endfunction

  function automatic logic [31:0] lin_c2(input logic [31:0] x);
    logic [31:0] y;
    for (int i = 0; i < 32; i++)
      y[i] = x[(LC2_A*i + LC2_B0) % 32] ^ x[(LC2_A*i + LC2_B1) % 32]
           ^ x[(LC2_A*i + LC2_B2) % 32];
    return y;
  endfunction

  function automatic logic [63:0] lin_t(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++)
      y[i] = x[(LT_A*i + LT_B0) % 64] ^ x[(LT_A*i + LT_B1) % 64]
           ^ x[(LT_A*i + LT_B2) % 64];
    return y;
  endfunction

  function automatic logic [127:0] lin_k(input logic [127:0] x);
    logic [127:0] y;
    for (int i = 0; i < 128; i++)
      y[i] = x[(LK_A*i + LK_B0) % 128] ^ x[(LK_A*i + LK_B1) % 128]
           ^ x[(LK_A*i + LK_B2) % 128];
    return y;
  endfunction

  // one full round; ridx is the round number 0..6
  function automatic stage_t round_f(input stage_t s, input logic [2:0] ridx);
    stage_t      r;
    logic [31:0] rc;
    logic [127:0] kx;
    rc = {29'd0, ridx} ^ (32'd1 << ({2'd0, ridx} + 5'd4));
    kx = s.k ^ {rc, 96'd0};
    r.k    = lin_k(chichi128(kx));
    r.t    = lin_t(chichi64(s.t));
    r.c1   = lin_c1(chichi32(s.c1)) ^ r.t[31:0];
    r.c2   = lin_c2(chichi32(s.c2)) ^ r.t[63:32];
    r.t    = r.t ^ r.k[63:0];
    r.etag = s.etag;
    return r;
  endfunction

endpackage

// ----- sv/tcdtc_round.sv -----
// ----------------------------------------------------------------------------
// tcdtc_round
// one registered round stage with valid/ready and bubble collapsing
// ----------------------------------------------------------------------------
module tcdtc_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        round_idx,
  input  logic              up_valid,
  output logic              up_ready,
  input  tcdtc_pkg::stage_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output tcdtc_pkg::stage_t dn_data
);
  import tcdtc_pkg::*;

  logic   valid_r;
  stage_t data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= round_f(up_data, round_idx);
    end
  end

endmodule

// ----- sv/tweakable_cipher_decrypt_tag_check_top.sv -----
// ----------------------------------------------------------------------------
// tweakable_cipher_decrypt_tag_check_top
// pipelined 32-bit tweakable block decryption with truncated tag check
// ----------------------------------------------------------------------------
// usage:
//   - cfg port: write key_low, key_high and tag_bits while no item is in
//     flight; each write lands at the clock edge where cfg_we is high
//   - input channel carries ciphertext, tweak and expected tag per item;
//     an item is taken when in_valid and in_ready are both high
//   - output channel gives plaintext (zero on mismatch) and tag_match,
//     exactly one result item per input item, in order
//   - pipeline path from input accept to out_valid: load stage, seven round
//     stages, final map stage, output register
//   - throughput: one item per cycle while out_ready is high; each round
//     has its own stage, so the ten registers set the latency, not the rate
//   - stall: when out_ready is low, items keep moving up into empty slots;
//     in_ready drops only once every stage and the output register are full
//   - reset (rst_n low, synchronous) empties the pipeline, clears the key
//     to zero and sets tag_bits to 8
// ----------------------------------------------------------------------------
module tweakable_cipher_decrypt_tag_check_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tcdtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcdtc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_ciphertext,
  input  logic [63:0]                         in_tweak,
  input  logic [tcdtc_pkg::TAG_W-1:0]         in_expected_tag,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         out_plaintext,
  output logic                                out_tag_match
);
  import tcdtc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [63:0]     key_low_r;
  logic [63:0]     key_high_r;
  logic [TB_W-1:0] tag_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      tag_bits_r <= TAG_BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_TAG_BITS: tag_bits_r <= cfg_wdata[TB_W-1:0];
        default:      ;   // unused index, write dropped
      endcase
    end
  end

  // ---------------- load stage: whitening ----------------
  logic   ld_valid_r;
  stage_t ld_data_r;
  logic   ld_ready;
  stage_t ld_nxt;

  // ready chain of the round stages, index NUM_ROUNDS is the final stage
  logic   rnd_ready [NUM_ROUNDS+1];
  logic   rnd_valid [NUM_ROUNDS+1];
  stage_t rnd_data  [NUM_ROUNDS+1];

  assign ld_ready = !ld_valid_r || rnd_ready[0];
  assign in_ready = ld_ready;

  always_comb begin
    ld_nxt.c1   = in_ciphertext ^ key_high_r[31:0];
    ld_nxt.c2   = in_ciphertext ^ key_high_r[63:32];
    ld_nxt.t    = in_tweak ^ key_low_r;
    ld_nxt.k    = {key_high_r, key_low_r};
    ld_nxt.etag = in_expected_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_valid_r <= 1'b0;
    end else if (ld_ready) begin
      ld_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ready && in_valid) begin
      ld_data_r <= ld_nxt;
    end
  end

  // ---------------- seven round stages ----------------
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    tcdtc_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (3'(g)),
      .up_valid  ((g == 0) ? ld_valid_r : rnd_valid[g]),
      .up_ready  (rnd_ready[g]),
      .up_data   ((g == 0) ? ld_data_r : rnd_data[g]),
      .dn_valid  (rnd_valid[g+1]),
      .dn_ready  (rnd_ready[g+1]),
      .dn_data   (rnd_data[g+1])
    );
  end

  // slot 0 of the arrays is fed by the load stage directly
  assign rnd_valid[0] = ld_valid_r;
  assign rnd_data[0]  = ld_data_r;

  // ---------------- final map stage ----------------
  logic   fin_valid_r;
  stage_t fin_data_r;
  logic   fin_ready;
  stage_t fin_nxt;
  stage_t fin_in;

  assign fin_in = rnd_data[NUM_ROUNDS];

  // closing chichi on both halves, linear layer alone on the tweak
  always_comb begin
    fin_nxt.c1   = chichi32(fin_in.c1);
    fin_nxt.c2   = chichi32(fin_in.c2);
    fin_nxt.t    = lin_t(fin_in.t);
    fin_nxt.k    = fin_in.k;
    fin_nxt.etag = fin_in.etag;
  end

  logic out_open;
  assign fin_ready             = !fin_valid_r || out_open;
  assign rnd_ready[NUM_ROUNDS] = fin_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_r <= rnd_valid[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && rnd_valid[NUM_ROUNDS]) begin
      fin_data_r <= fin_nxt;
    end
  end

  // ---------------- tag compare and output register ----------------
  logic [31:0]      tag_word;
  logic [5:0]       tag_shift;
  logic [TAG_W-1:0] tag_calc;
  logic             match_nxt;
  logic [31:0]      pt_nxt;

  always_comb begin
    tag_word  = fin_data_r.c2 ^ fin_data_r.t[63:32];
    tag_shift = 6'd32 - {1'b0, tag_bits_r};
    if (tag_bits_r == '0) begin
      tag_calc = '0;
    end else begin
      tag_calc = TAG_W'(tag_word >> tag_shift);
    end
    match_nxt = (tag_calc == fin_data_r.etag);
    // plaintext only released on a tag match
    pt_nxt    = match_nxt ? (fin_data_r.c1 ^ fin_data_r.t[31:0]) : 32'd0;
  end

  logic        out_valid_r;
  logic [31:0] out_plaintext_r;
  logic        out_tag_match_r;

  assign out_open = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && fin_valid_r) begin
      out_plaintext_r <= pt_nxt;
      out_tag_match_r <= match_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_plaintext = out_plaintext_r;
  assign out_tag_match = out_tag_match_r;

endmodule

// ----- sv/tcdtc_checker.sv -----
// ----------------------------------------------------------------------------
// tcdtc_checker
// port level checks of the decrypt core, bound to the top level
// ----------------------------------------------------------------------------
module tcdtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_plaintext,
  input logic        out_tag_match
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_plaintext)
      && $stable(out_tag_match))
    else $error("stalled result item changed");

  // failed tag never leaks plaintext
  a_no_leak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tag_match |-> out_plaintext == 32'd0)
    else $error("plaintext released on tag mismatch");

  // input backpressure only comes from a stalled output
  a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

endmodule

bind tweakable_cipher_decrypt_tag_check_top tcdtc_checker u_tcdtc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_plaintext (out_plaintext),
  .out_tag_match (out_tag_match)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tweakable 32-bit decrypt core with tag check
// ----------------------------------------------------------------------------
// a short table of directed vectors runs first, then randomized phases, each
// under its own key and tag width. every accepted item is decrypted by a
// bit-level model kept in this file, and each result item is compared field
// by field against the oldest pending prediction. both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcdtc_pkg::*;

  localparam int LATENCY     = 9;     // accept to out_valid, no stall
  localparam int QUIET_LIMIT = 1000;  // cycles with no handshake at all
  localparam int ROUNDS      = 7;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int N_DIRECTED  = 21;

  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_A  = 64'h0F0F_0F0F_0F0F_0F0F;
  localparam logic [63:0] KEY_B  = 64'hF0E1_D2C3_B4A5_9687;
  localparam logic [63:0] TW_MIX = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] TW_ALT = 64'h5A5A_5A5A_5A5A_5A5A;

  typedef struct packed {
    logic [31:0] plaintext;
    logic        tag_match;
  } result_t;

  // one directed vector: setting, item, and an optional typed-in result
  typedef struct packed {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  tbits;
    logic [31:0] ct;
    logic [63:0] tw;
    logic [15:0] etag;
    logic        auto_tag;     // send the tag the core should compute
    logic        typed;        // result below is used instead of the model
    logic [31:0] typed_pt;
    logic        typed_match;
  } vector_t;

  // key_lo key_hi tbits ct tw etag auto_tag typed typed_pt typed_match
  vector_t directed_rows [N_DIRECTED] = '{
    // reset key and width 8: the tag never exceeds 8 bits, so wider tags miss
    '{64'd0, 64'd0, 5'd8, 32'h0000_0000, 64'd0, 16'hFF00, 1'b0, 1'b1, 32'd0, 1'b0},
    '{64'd0, 64'd0, 5'd8, 32'hFFFF_FFFF, ONES64, 16'hFFFF, 1'b0, 1'b1, 32'd0, 1'b0},
    '{64'd0, 64'd0, 5'd8, 32'h0000_0000, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{64'd0, 64'd0, 5'd8, 32'h1234_5678, TW_MIX, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    // all-ones key, full 16-bit tag
    '{ONES64, ONES64, 5'd16, 32'h0000_0000, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ONES64, ONES64, 5'd16, 32'hFFFF_FFFF, ONES64, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ONES64, ONES64, 5'd16, 32'hA5A5_A5A5, TW_ALT, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ONES64, ONES64, 5'd16, 32'h0000_0000, ONES64, 16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0},
    // one-bit tag: anything above 1 can never match
    '{ONES64, 64'd0, 5'd1, 32'h8000_0001, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ONES64, 64'd0, 5'd1, 32'h8000_0001, 64'd0, 16'h0002, 1'b0, 1'b1, 32'd0, 1'b0},
    '{ONES64, 64'd0, 5'd1, 32'h7FFF_FFFE, ONES64, 16'h8001, 1'b0, 1'b1, 32'd0, 1'b0},
    // zero-width tag computes as zero: only a zero tag passes
    '{64'd0, ONES64, 5'd0, 32'hDEAD_BEEF, 64'd0, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{64'd0, ONES64, 5'd0, 32'hDEAD_BEEF, 64'd0, 16'hFFFF, 1'b0, 1'b1, 32'd0, 1'b0},
    '{64'd0, ONES64, 5'd0, 32'h0000_0000, ONES64, 16'h0001, 1'b0, 1'b1, 32'd0, 1'b0},
    // widths past 16: shifted word keeps only its low 16 bits
    '{KEY_A, KEY_B, 5'd31, 32'h0000_0000, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{KEY_A, KEY_B, 5'd31, 32'hFFFF_FFFF, ONES64, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{KEY_A, KEY_B, 5'd31, 32'h1357_9BDF, TW_MIX, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{KEY_A, KEY_B, 5'd17, 32'h0000_0000, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{KEY_A, KEY_B, 5'd17, 32'h2468_ACE0, ONES64, 16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0},
    // back to a zero key with the widest sensible tag
    '{64'd0, 64'd0, 5'd16, 32'hFFFF_FFFF, 64'd0, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{64'd0, 64'd0, 5'd16, 32'h0000_0000, ONES64, 16'h8000, 1'b0, 1'b0, 32'd0, 1'b0}
  };

  // tag width used by each random phase, extremes included
  logic [4:0] phase_tag_bits [N_PHASES] = '{5'd16, 5'd1, 5'd8, 5'd0,
                                            5'd31, 5'd12, 5'd17, 5'd4};

  // ports; every input to the core is known from time zero
  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             cfg_we          = 1'b0;
  cfg_reg_t         cfg_index       = REG_KEY_LOW;
  logic [63:0]      cfg_wdata       = '0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic [31:0]      in_ciphertext   = '0;
  logic [63:0]      in_tweak        = '0;
  logic [TAG_W-1:0] in_expected_tag = '0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [31:0]      out_plaintext;
  logic             out_tag_match;

  // shadow of the register file as the core should hold it
  logic [63:0] key_low_q  = '0;
  logic [63:0] key_high_q = '0;
  logic [4:0]  tag_bits_q = TAG_BITS_RESET;

  result_t decrypted_q [$];   // predicted result items, oldest first
  bit      failed       = 1'b0;
  int      send_calm    = 0;  // items left in a run with no sender gaps
  int      stall_left   = 0;
  int      ready_calm   = 0;
  int      ready_roll;
  int      quiet_cycles = 0;
  result_t head;

  always #10 clk = ~clk;

  tweakable_cipher_decrypt_tag_check_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ciphertext   (in_ciphertext),
    .in_tweak        (in_tweak),
    .in_expected_tag (in_expected_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_plaintext   (out_plaintext),
    .out_tag_match   (out_tag_match)
  );

  // ---------------------------------------------------------------------------
  // bit-level decryption model
  // ---------------------------------------------------------------------------

  // nonlinear map on the low n bits (n = 32, 64 or 128)
  function automatic logic [127:0] chi_map(input logic [127:0] x, input int n);
    int           m;
    logic [127:0] y;
    m = n / 2;
    y = '0;
    for (int i = 0; i < n; i++) begin
      if (i + 3 < m || (i > m && i + 2 < n)) y[i] = x[i] ^ (~x[i+1] & x[i+2]);
      else if (i == m - 3) y[i] = x[m] ^ (~x[m-2] & x[0]);
      else if (i == m - 2) y[i] = x[m-1] ^ (~x[0] & x[1]);
      else if (i == m - 1) y[i] = ~x[m-3] ^ (~x[m] & ~x[m+1]);
      else if (i == m)     y[i] = x[m-2] ^ (~x[m+1] & x[m+2]);
      else if (i == n - 2) y[i] = x[n-2] ^ (~x[n-1] & x[m-1]);
      else                 y[i] = x[n-1] ^ (~x[m-1] & x[m]);
    end
    return y;
  endfunction

  // each output bit is the xor of three taps at a*i + offset, mod n
  function automatic logic [127:0] mix_bits(input logic [127:0] x, input int n,
                                            input int a, input int o0,
                                            input int o1, input int o2);
    logic [127:0] y;
    y = '0;
    for (int i = 0; i < n; i++)
      y[i] = x[(a*i + o0) % n] ^ x[(a*i + o1) % n] ^ x[(a*i + o2) % n];
    return y;
  endfunction

  // full decryption under the shadow key: candidate plaintext and tag word
  function automatic void decrypt_block(input logic [31:0] ct, input logic [63:0] tw,
                                        output logic [31:0] pt,
                                        output logic [31:0] tag_word);
    logic [127:0] k;
    logic [31:0]  h1, h2, rc;
    logic [63:0]  t, tl;
    k  = {key_high_q, key_low_q};
    h1 = ct ^ key_high_q[31:0];
    h2 = ct ^ key_high_q[63:32];
    t  = tw ^ key_low_q;
    for (int r = 0; r < ROUNDS; r++) begin
      // round constant lands in the top key word only
      rc = 32'(r) ^ (32'd1 << (r + 4));
      k[127:96] = k[127:96] ^ rc;
      h1 = 32'(mix_bits(chi_map({96'd0, h1}, 32), 32, 11, 5, 9, 12));
      h2 = 32'(mix_bits(chi_map({96'd0, h2}, 32), 32, 11, 1, 26, 30));
      t  = 64'(mix_bits(chi_map({64'd0, t}, 64), 64, 3, 1, 26, 50));
      k  = mix_bits(chi_map(k, 128), 128, 17, 7, 11, 14);
      h1 = h1 ^ t[31:0];
      h2 = h2 ^ t[63:32];
      t  = t ^ k[63:0];
    end
    h1 = 32'(chi_map({96'd0, h1}, 32));
    h2 = 32'(chi_map({96'd0, h2}, 32));
    tl = 64'(mix_bits({64'd0, t}, 64, 3, 1, 26, 50));
    pt       = h1 ^ tl[31:0];
    tag_word = h2 ^ tl[63:32];
  endfunction

  // top bits of the tag word; zero width gives zero, wide widths wrap at 16
  function automatic logic [15:0] truncated_tag(input logic [31:0] tag_word,
                                                input logic [4:0] width);
    if (width == 5'd0) return 16'd0;
    return 16'(tag_word >> (32 - int'(width)));
  endfunction

  // plaintext is released only when the full 16-bit tag compare hits
  function automatic result_t tag_verdict(input logic [31:0] pt, input logic [31:0] tag_word,
                                          input logic [15:0] etag);
    result_t res;
    res.tag_match = (truncated_tag(tag_word, tag_bits_q) == etag);
    res.plaintext = res.tag_match ? pt : 32'd0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one or a calm run
  function automatic int sender_gap();
    int roll;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      send_calm = $urandom_range(20, 100);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // valid stays up across back-to-back items; here it only drops for a gap
  task automatic send_item(input logic [31:0] ct, input logic [63:0] tw,
                           input logic [15:0] etag, input result_t want);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_ciphertext   <= ct;
    in_tweak        <= tw;
    in_expected_tag <= etag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decrypted_q.push_back(want);
  endtask

  // hold off the sender until every pending result item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (decrypted_q.size() != 0);
  endtask

  // rewrite all three registers on an empty pipeline
  task automatic load_setting(input logic [63:0] klo, input logic [63:0] khi,
                              input logic [4:0] tbits);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= klo;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= khi;
    @(posedge clk);
    cfg_index <= REG_TAG_BITS;
    cfg_wdata <= {59'd0, tbits};
    @(posedge clk);
    cfg_we     <= 1'b0;
    key_low_q  = klo;
    key_high_q = khi;
    tag_bits_q = tbits;
  endtask

  initial begin
    vector_t     row;
    result_t     want;
    logic [31:0] ct, pt, tag_word;
    logic [63:0] tw, klo, khi;
    logic [15:0] etag;
    int          roll;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed vectors; the first rows run on the reset setting untouched
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.key_lo !== key_low_q || row.key_hi !== key_high_q ||
          row.tbits !== tag_bits_q)
        load_setting(row.key_lo, row.key_hi, row.tbits);
      decrypt_block(row.ct, row.tw, pt, tag_word);
      etag = row.auto_tag ? truncated_tag(tag_word, tag_bits_q) : row.etag;
      if (row.typed) begin
        want.plaintext = row.typed_pt;
        want.tag_match = row.typed_match;
      end else begin
        want = tag_verdict(pt, tag_word, etag);
      end
      send_item(row.ct, row.tw, etag, want);
    end

    // random phases: mostly authentic tags so plaintext paths get exercised
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          klo = ONES64;
          khi = ONES64;
        end
        1: begin
          klo = '0;
          khi = '0;
        end
        default: begin
          klo = {$urandom, $urandom};
          khi = {$urandom, $urandom};
        end
      endcase
      load_setting(klo, khi, phase_tag_bits[ph]);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // full drain mid-run, once for sure in the first phase and sometimes more
        if ((ph == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 299) == 0)
          wait_drained();

        roll = $urandom_range(0, 99);
        if (roll < 5)       ct = '0;
        else if (roll < 10) ct = '1;
        else                ct = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 5)       tw = '0;
        else if (roll < 10) tw = ONES64;
        else                tw = {$urandom, $urandom};

        decrypt_block(ct, tw, pt, tag_word);
        roll = $urandom_range(0, 99);
        if (roll < 70)      etag = truncated_tag(tag_word, tag_bits_q);
        else if (roll < 85) etag = truncated_tag(tag_word, tag_bits_q)
                                   ^ (16'd1 << $urandom_range(0, 15));
        else                etag = 16'($urandom);

        send_item(ct, tw, etag, tag_verdict(pt, tag_word, etag));
      end
    end

    // let the pipe empty, then watch a little longer for stray results
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (!failed) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: check accepted results and randomize ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decrypted_q.size() == 0) begin
          $error("result item with nothing pending: plaintext %h tag_match %b",
                 out_plaintext, out_tag_match);
          failed = 1'b1;
        end else begin
          head = decrypted_q.pop_front();
          if (out_plaintext !== head.plaintext) begin
            $error("plaintext: expected %h, got %h", head.plaintext, out_plaintext);
            failed = 1'b1;
          end
          if (out_tag_match !== head.tag_match) begin
            $error("tag_match: expected %b, got %b", head.tag_match, out_tag_match);
            failed = 1'b1;
          end
        end
      end

      // short stalls are common, long ones rare, with calm runs between
      if (stall_left > 0) begin
        stall_left--;
      end else if (ready_calm > 0) begin
        ready_calm--;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 3)       ready_calm = $urandom_range(30, 150);
        else if (ready_roll < 23) stall_left = $urandom_range(1, 3);
        else if (ready_roll < 26) stall_left = $urandom_range(10, 40);
      end
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog: too long without any handshake means the core is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
sv/tcdtc_pkg.sv
sv/tcdtc_round.sv
sv/tweakable_cipher_decrypt_tag_check_top.sv
sv/tcdtc_checker.sv
bench/tb.sv
